// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising clock edge, ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Assert that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/core/cpf_pkg.sv =====
// Types, constants and the CRC-8 update function of the packet framer.
`default_nettype none

package cpf_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] HEAD0_BYTE     = 8'h55;
    localparam logic [BYTE_W-1:0] HEAD1_BYTE     = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL0_BYTE     = 8'h0D;
    localparam logic [BYTE_W-1:0] TAIL1_BYTE     = 8'h0A;
    localparam logic [BYTE_W-1:0] CRC_POLY       = 8'h1D;
    localparam logic [BYTE_W-1:0] CRC_INIT       = 8'hFF;
    localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd7;

    // One emitted byte with its markers.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_of_item;
        logic              end_of_frame;
    } beat_t;

    // Fold one byte into the CRC, MSB first, no reflection.
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cpf_out_stage.sv =====
// Output register stage: holds one byte request until the sink takes it.
`default_nettype none

module cpf_out_stage
    import cpf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire beat_t beat_in,
    output logic       free,
    output logic       byte_valid,
    input  wire logic  byte_ready,
    output beat_t      beat_out
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    // Free when empty or when the held request leaves this cycle.
    assign free       = !valid_reg || byte_ready;
    assign valid_next = load || (valid_reg && !byte_ready);

    // Hold valid state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture payload on load.
    always_ff @(posedge clk)
    begin
        if (load)
            beat_reg <= beat_in;
    end

    assign byte_valid = valid_reg;
    assign beat_out   = beat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crc8_packet_framer.sv =====
// Top level: CRC-8 packet framer, one frame byte per cycle while the sink is ready.
// Accepted items are held in the item registers; each byte is registered in the output stage.
// Throughput: one byte per cycle unless stalled; an item makes 2 to 9 frame bytes.
// A mid-frame word item makes two bytes; the next item is taken as its last byte is emitted.
// Reset: no item held, no byte pending, no frame open, CRC back at 0xFF.
`default_nettype none

module crc8_packet_framer
    import cpf_pkg::*;
#(
    parameter int unsigned MAX_WORDS = 124
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic [WORD_W-1:0]  word_value,
    input  wire logic [COUNT_W-1:0] word_count,
    input  wire logic [BYTE_W-1:0]  message_code,
    output logic                    byte_valid,
    input  wire logic               byte_ready,
    output logic [BYTE_W-1:0]       frame_byte,
    output logic                    last_of_item,
    output logic                    end_of_frame
);

    typedef enum logic [3:0] {
        ST_HEAD0,
        ST_HEAD1,
        ST_LEN,
        ST_CODE,
        ST_WLO,
        ST_WHI,
        ST_CRC,
        ST_TAIL0,
        ST_TAIL1
    } step_t;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_WORDS);

    logic               cur_valid_reg;
    logic               cur_valid_next;
    step_t              step_reg;
    step_t              step_next;
    step_t              step_after;
    logic [WORD_W-1:0]  word_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [BYTE_W-1:0]  code_reg;
    logic [BYTE_W-1:0]  crc_reg;
    logic [BYTE_W-1:0]  crc_next;
    logic [COUNT_W-1:0] words_remaining_reg;
    logic [COUNT_W-1:0] words_remaining_next;
    logic [COUNT_W-1:0] rem_dec;
    logic [COUNT_W-1:0] count_sat;
    logic               inside_frame;
    logic               out_free;
    logic               emit;
    logic               fold;
    logic               item_done;
    logic               load;
    beat_t              beat;
    beat_t              beat_out;

    assign emit     = cur_valid_reg && out_free;
    assign rem_dec  = words_remaining_reg - COUNT_W'(1);
    assign count_sat = (word_count > MAX_COUNT) ? MAX_COUNT : word_count;

    // Pick the byte for the current step and the step after it.
    always_comb
    begin
        beat.frame_byte   = HEAD0_BYTE;
        beat.end_of_frame = 1'b0;
        fold              = 1'b1;
        item_done         = 1'b0;
        step_after        = ST_HEAD0;
        unique case (step_reg)
            ST_HEAD0:
            begin
                beat.frame_byte = HEAD0_BYTE;
                step_after      = ST_HEAD1;
            end
            ST_HEAD1:
            begin
                beat.frame_byte = HEAD1_BYTE;
                step_after      = ST_LEN;
            end
            ST_LEN:
            begin
                beat.frame_byte = BYTE_W'({count_reg, 1'b0}) + FRAME_OVERHEAD;
                step_after      = ST_CODE;
            end
            ST_CODE:
            begin
                beat.frame_byte = code_reg;
                step_after      = (count_reg == '0) ? ST_CRC : ST_WLO;
            end
            ST_WLO:
            begin
                beat.frame_byte = word_reg[BYTE_W-1:0];
                step_after      = ST_WHI;
            end
            ST_WHI:
            begin
                beat.frame_byte = word_reg[WORD_W-1:BYTE_W];
                step_after      = ST_CRC;
                item_done       = (rem_dec != '0);
            end
            ST_CRC:
            begin
                beat.frame_byte = crc_reg;
                fold            = 1'b0;
                step_after      = ST_TAIL0;
            end
            ST_TAIL0:
            begin
                beat.frame_byte = TAIL0_BYTE;
                fold            = 1'b0;
                step_after      = ST_TAIL1;
            end
            ST_TAIL1:
            begin
                beat.frame_byte   = TAIL1_BYTE;
                beat.end_of_frame = 1'b1;
                fold              = 1'b0;
                item_done         = 1'b1;
            end
            default:
            begin
                beat.frame_byte = HEAD0_BYTE;
            end
        endcase
        beat.last_of_item = item_done;
    end

    // Advance frame state on each emitted byte.
    always_comb
    begin
        crc_next             = crc_reg;
        words_remaining_next = words_remaining_reg;
        if (emit)
        begin
            if (fold)
                crc_next = crc8_update(crc_reg, beat.frame_byte);
            else if (step_reg == ST_TAIL1)
                crc_next = CRC_INIT;
            if (step_reg == ST_CODE)
                words_remaining_next = count_reg;
            else if (step_reg == ST_WHI)
                words_remaining_next = rem_dec;
        end
    end

    // Take a new request when the item slot is empty or finishing now.
    assign item_ready   = !cur_valid_reg || (emit && item_done);
    assign load         = item_valid && item_ready;
    assign inside_frame = (words_remaining_next != '0);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (emit)
        begin
            step_next = step_after;
            if (item_done)
                cur_valid_next = 1'b0;
        end
        if (load)
        begin
            cur_valid_next = 1'b1;
            step_next      = inside_frame ? ST_WLO : ST_HEAD0;
        end
    end

    // Hold control and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg       <= 1'b0;
            step_reg            <= ST_HEAD0;
            crc_reg             <= CRC_INIT;
            words_remaining_reg <= '0;
        end
        else
        begin
            cur_valid_reg       <= cur_valid_next;
            step_reg            <= step_next;
            crc_reg             <= crc_next;
            words_remaining_reg <= words_remaining_next;
        end
    end

    // Capture the item payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg  <= word_value;
            count_reg <= count_sat;
            code_reg  <= message_code;
        end
    end

    cpf_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .beat_in    (beat),
        .free       (out_free),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .beat_out   (beat_out)
    );

    assign frame_byte   = beat_out.frame_byte;
    assign last_of_item = beat_out.last_of_item;
    assign end_of_frame = beat_out.end_of_frame;

endmodule

`default_nettype wire

// ===== rtl/core/cpf_checker.sv =====
// Port-level checker for the packet framer and its bind.
`default_nettype none
`include "assert_macros.svh"

module cpf_checker
    import cpf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire logic              byte_valid,
    input wire logic              byte_ready,
    input wire logic [BYTE_W-1:0] frame_byte,
    input wire logic              last_of_item,
    input wire logic              end_of_frame
);

    logic [1:0] pending_reg;
    logic       item_take;
    logic       item_finish;

    assign item_take   = item_valid && item_ready;
    assign item_finish = byte_valid && byte_ready && last_of_item;

    // Track requests taken but not fully delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 2'(item_take) - 2'(item_finish);
    end

    `ASSERT_CLK(a_byte_hold, clk, rst_n, byte_valid && !byte_ready |=> byte_valid && $stable(frame_byte))
    `ASSERT_CLK(a_eof_shape, clk, rst_n, byte_valid && end_of_frame |-> last_of_item && frame_byte == TAIL1_BYTE)
    `ASSERT_NEVER(a_no_orphan, clk, rst_n, item_finish && pending_reg == 2'd0)
    `ASSERT_NEVER(a_depth, clk, rst_n, pending_reg == 2'd3)

endmodule

bind crc8_packet_framer cpf_checker u_cpf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .frame_byte   (frame_byte),
    .last_of_item (last_of_item),
    .end_of_frame (end_of_frame)
);

`default_nettype wire

// ===== sim/crc8_packet_framer_checker.sv =====
// Checker for the packet framer: predicts frame bytes from requests and compares outputs.
`timescale 1ns / 1ps

module crc8_packet_framer_checker
    import cpf_pkg::*;
#(
    parameter int unsigned MAX_WORDS = 124
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  logic [WORD_W-1:0]  word_value,
    input  logic [COUNT_W-1:0] word_count,
    input  logic [BYTE_W-1:0]  message_code,
    input  logic               byte_valid,
    input  logic               byte_ready,
    input  logic [BYTE_W-1:0]  frame_byte,
    input  logic               last_of_item,
    input  logic               end_of_frame,
    output int unsigned        errors,
    output int unsigned        pending
);

    // Framer state as the predictor sees it
    logic [BYTE_W-1:0]  crc_acc;
    logic [COUNT_W-1:0] words_left;
    logic               frame_open;

    // Bytes caused by the current request, then the queue of bytes still owed
    beat_t item_beats [0:8];
    int    item_len;
    beat_t expected_beats [$];

    // Fold one byte into the CRC, one data bit at a time, MSB first
    function automatic logic [BYTE_W-1:0] crc8_fold(
        input logic [BYTE_W-1:0] acc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] r;
        logic              fb;
        int                i;
        r = acc;
        for (i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = r[BYTE_W-1] ^ data[i];
            r  = {r[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return r;
    endfunction

    // Append one byte to the current request's burst, folding it into the CRC if covered
    task automatic add_beat(input logic [BYTE_W-1:0] b, input bit covered);
        item_beats[item_len].frame_byte   = b;
        item_beats[item_len].last_of_item = 1'b0;
        item_beats[item_len].end_of_frame = 1'b0;
        item_len++;
        if (covered)
            crc_acc = crc8_fold(crc_acc, b);
    endtask

    // Close the frame: CRC byte, CR, LF
    task automatic add_trailer();
        add_beat(crc_acc, 1'b0);
        add_beat(TAIL0_BYTE, 1'b0);
        add_beat(TAIL1_BYTE, 1'b0);
        item_beats[item_len-1].end_of_frame = 1'b1;
        crc_acc    = CRC_INIT;
        words_left = '0;
        frame_open = 1'b0;
    endtask

    // Work out every byte one accepted request produces and queue them
    task automatic predict_item(
        input logic [WORD_W-1:0]  word,
        input logic [COUNT_W-1:0] count,
        input logic [BYTE_W-1:0]  code
    );
        logic [COUNT_W-1:0] n_words;
        logic [BYTE_W-1:0]  len_byte;
        int                 k;
        item_len = 0;
        // Open a new frame: header, length, code
        if (!frame_open)
        begin
            n_words  = (count > MAX_WORDS) ? COUNT_W'(MAX_WORDS) : count;
            len_byte = {n_words, 1'b0} + FRAME_OVERHEAD;
            crc_acc  = CRC_INIT;
            add_beat(HEAD0_BYTE, 1'b1);
            add_beat(HEAD1_BYTE, 1'b1);
            add_beat(len_byte, 1'b1);
            add_beat(code, 1'b1);
            if (n_words == '0)
                add_trailer();
            else
            begin
                frame_open = 1'b1;
                words_left = n_words;
            end
        end
        // Payload word, low byte first
        if (frame_open)
        begin
            add_beat(word[7:0], 1'b1);
            add_beat(word[15:8], 1'b1);
            words_left = words_left - 1'b1;
            if (words_left == '0)
                add_trailer();
        end
        item_beats[item_len-1].last_of_item = 1'b1;
        for (k = 0; k < item_len; k++)
            expected_beats.push_back(item_beats[k]);
    endtask

    // Watch both channels on each rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        beat_t want;
        if (!rst_n)
        begin
            crc_acc    = CRC_INIT;
            words_left = '0;
            frame_open = 1'b0;
            errors     = 0;
            expected_beats.delete();
            pending    = 0;
        end
        else
        begin
            // Predict from an accepted request
            if (item_valid && item_ready)
                predict_item(word_value, word_count, message_code);
            // Compare an accepted byte against the oldest expectation
            if (byte_valid && byte_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected byte: expected none, actual %02h last %b eof %b",
                             $time, frame_byte, last_of_item, end_of_frame);
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (frame_byte !== want.frame_byte)
                    begin
                        $display("%0t: frame_byte expected %02h actual %02h",
                                 $time, want.frame_byte, frame_byte);
                        errors++;
                    end
                    if (last_of_item !== want.last_of_item)
                    begin
                        $display("%0t: last_of_item expected %b actual %b",
                                 $time, want.last_of_item, last_of_item);
                        errors++;
                    end
                    if (end_of_frame !== want.end_of_frame)
                    begin
                        $display("%0t: end_of_frame expected %b actual %b",
                                 $time, want.end_of_frame, end_of_frame);
                        errors++;
                    end
                end
            end
            pending = expected_beats.size();
        end
    end

endmodule

// ===== sim/crc8_packet_framer_tb.sv =====
// Testbench top for the packet framer: clock, reset, request and byte-side traffic, verdict.
`timescale 1ns / 1ps

module crc8_packet_framer_tb;
    import cpf_pkg::*;

    localparam int unsigned MAX_WORDS   = 124;
    localparam int          TOTAL_ITEMS = 160;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    logic [WORD_W-1:0]  word_value;
    logic [COUNT_W-1:0] word_count;
    logic [BYTE_W-1:0]  message_code;
    logic               byte_valid;
    logic               byte_ready;
    logic [BYTE_W-1:0]  frame_byte;
    logic               last_of_item;
    logic               end_of_frame;

    int unsigned check_errors;
    int unsigned pending_bytes;
    int          items_sent;
    bit          tx_steady;

    crc8_packet_framer #(
        .MAX_WORDS    (MAX_WORDS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .word_value   (word_value),
        .word_count   (word_count),
        .message_code (message_code),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .frame_byte   (frame_byte),
        .last_of_item (last_of_item),
        .end_of_frame (end_of_frame)
    );

    crc8_packet_framer_checker #(
        .MAX_WORDS    (MAX_WORDS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .word_value   (word_value),
        .word_count   (word_count),
        .message_code (message_code),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .frame_byte   (frame_byte),
        .last_of_item (last_of_item),
        .end_of_frame (end_of_frame),
        .errors       (check_errors),
        .pending      (pending_bytes)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Issue one request after a random gap; returns at the falling edge after acceptance
    task automatic send_item(
        input logic [WORD_W-1:0]  word,
        input logic [COUNT_W-1:0] count,
        input logic [BYTE_W-1:0]  code
    );
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        word_value   <= word;
        word_count   <= count;
        message_code <= code;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Send a whole frame with random payload; fields inside the frame are random noise
    task automatic send_frame(input int n_words, input logic [BYTE_W-1:0] code);
        int n_items;
        int i;
        n_items   = (n_words == 0) ? 1 : ((n_words > MAX_WORDS) ? MAX_WORDS : n_words);
        tx_steady = ($urandom_range(0, 4) == 0);
        send_item(WORD_W'($urandom_range(0, 65535)), COUNT_W'(n_words), code);
        for (i = 1; i < n_items; i++)
            send_item(WORD_W'($urandom_range(0, 65535)),
                      COUNT_W'($urandom_range(0, 127)),
                      BYTE_W'($urandom_range(0, 255)));
    endtask

    // Byte side: stall a random number of cycles before each byte, with stall-free stretches
    initial
    begin : byte_sink
        int stall;
        int bytes_seen;
        bit rx_steady;
        byte_ready = 1'b0;
        bytes_seen = 0;
        rx_steady  = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (bytes_seen % 40 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                byte_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            byte_ready <= 1'b1;
            @(posedge clk);
            while (!byte_valid)
                @(posedge clk);
            bytes_seen++;
            @(negedge clk);
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("crc8_packet_framer_tb NOT OK");
        $finish;
    end

    // Request side: reset, directed frames, random frames, drain, verdict
    initial
    begin : stimulus
        int frame_idx;
        int big_frame;
        int r;
        int n_words;
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        word_value   = '0;
        word_count   = '0;
        message_code = '0;
        items_sent   = 0;
        tx_steady    = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty frames: word ignored, code extremes
        send_item(16'hFFFF, 7'd0, 8'h00);
        send_item(16'h0000, 7'd0, 8'hFF);
        // One-word frames with extreme words
        send_item(16'h0000, 7'd1, 8'h5A);
        send_item(16'hFFFF, 7'd1, 8'hA5);
        // Count and code inside a frame are ignored, even all ones or zero
        send_item(16'h1234, 7'd2, 8'h80);
        send_item(16'hFFFF, 7'h7F, 8'hFF);
        send_item(16'h00FF, 7'd3, 8'h01);
        send_item(16'hFF00, 7'd0, 8'h00);
        send_item(16'h8001, 7'h40, 8'h7F);
        // Back-to-back requests with alternating bit patterns
        tx_steady = 1'b1;
        send_item(16'hAAAA, 7'd4, 8'hC3);
        send_item(16'h5555, 7'h55, 8'h3C);
        send_item(16'hAAAA, 7'h2A, 8'hAA);
        send_item(16'h5555, 7'd1, 8'h55);
        send_item(16'h0000, 7'd0, 8'h00);

        // Random frames, mostly short, with one saturating frame of full size
        frame_idx = 0;
        big_frame = $urandom_range(0, 4);
        while (items_sent < TOTAL_ITEMS || frame_idx <= big_frame)
        begin
            if (frame_idx == big_frame)
            begin
                send_frame($urandom_range(MAX_WORDS + 1, 127), BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 2)
                    n_words = 0;
                else if (r == 9)
                    n_words = $urandom_range(7, 20);
                else
                    n_words = $urandom_range(1, 6);
                send_frame(n_words, BYTE_W'($urandom_range(0, 255)));
            end
            frame_idx++;
        end
        item_valid <= 1'b0;

        // Drain outstanding bytes, then allow for stray output
        while (pending_bytes != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        @(negedge clk);
        if (check_errors == 0)
            $display("crc8_packet_framer_tb OK");
        else
            $display("crc8_packet_framer_tb NOT OK");
        $finish;
    end

endmodule
